// ===== rtl/cnlc_pkg.sv =====
// Shared types, constants and helper functions for the card number checker.
// No dependencies; used by cnlc_ctrl, cnlc_dp and card_number_luhn_classifier.
`default_nettype none

package cnlc_pkg;

    localparam int NUM_W      = 63;
    localparam int DIGITS     = 19;
    localparam int BCD_W      = DIGITS * 4;
    localparam int STEP_BITS  = 3;
    localparam int CONV_STEPS = NUM_W / STEP_BITS;
    localparam int CNT_W      = 5;
    localparam int TOTAL_W    = 8;

    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(CONV_STEPS - 1);
    localparam logic [CNT_W-1:0] WALK_LAST = CNT_W'(DIGITS - 1);

    localparam logic [1:0] CLS_INVALID = 2'd0;
    localparam logic [1:0] CLS_FIFTEEN = 2'd1;
    localparam logic [1:0] CLS_SIXTEEN = 2'd2;
    localparam logic [1:0] CLS_LEAD4   = 2'd3;

    localparam logic [CNT_W-1:0] LEN_13 = CNT_W'(13);
    localparam logic [CNT_W-1:0] LEN_15 = CNT_W'(15);
    localparam logic [CNT_W-1:0] LEN_16 = CNT_W'(16);

    typedef logic [BCD_W-1:0] bcd_t;

    typedef struct packed {
        logic             load;
        logic             conv;
        logic             walk;
        logic             finish;
        logic [CNT_W-1:0] pos;
    } cnlc_cmd_t;

    // One double-dabble step: adjust every digit, then shift in one bit.
    function automatic bcd_t bcd_shift(input bcd_t bcd, input logic b);
        bcd_t adj;
        adj = bcd;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    // Digit sum of twice a decimal digit.
    function automatic logic [3:0] dbl_sum(input logic [3:0] d);
        logic [3:0] r;
        case (d)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cnlc_ctrl.sv =====
// Sequencer for the card number checker: load, convert, digit walk, result.
// Depends on cnlc_pkg; drives cnlc_dp through a command struct.
`default_nettype none

module cnlc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output cnlc_pkg::cnlc_cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [cnlc_pkg::CNT_W-1:0] step_reg, step_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       can_finish;

    assign can_finish = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.load       = 1'b0;
        cmd.conv       = 1'b0;
        cmd.walk       = 1'b0;
        cmd.finish     = 1'b0;
        cmd.pos        = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (step_reg == cnlc_pkg::CONV_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_WALK;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (step_reg == cnlc_pkg::WALK_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (can_finish)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cnlc_dp.sv =====
// Datapath: 3-bit-per-cycle binary to BCD conversion, Luhn digit walk, classify.
// Depends on cnlc_pkg; commanded by cnlc_ctrl.
`default_nettype none

module cnlc_dp (
    input  wire logic                          clk,
    input  wire cnlc_pkg::cnlc_cmd_t           cmd,
    input  wire logic [cnlc_pkg::NUM_W-1:0]    number_value,
    output logic [1:0]                         card_class,
    output logic                               checksum_ok,
    output logic [cnlc_pkg::TOTAL_W-1:0]       luhn_total,
    output logic [cnlc_pkg::CNT_W-1:0]         digit_count
);

    logic [cnlc_pkg::NUM_W-1:0]   bin_reg;
    cnlc_pkg::bcd_t               bcd_reg, bcd_conv;
    logic [cnlc_pkg::TOTAL_W-1:0] total_reg;
    logic [3:0]                   mod_reg, mod_next;
    logic [4:0]                   mod_sum;
    logic [cnlc_pkg::CNT_W-1:0]   count_reg;
    logic [3:0]                   top_reg, second_reg, prev_reg;
    logic [3:0]                   digit, contrib;
    logic [1:0]                   cls;

    logic [1:0]                   card_class_reg;
    logic                         checksum_ok_reg;
    logic [cnlc_pkg::TOTAL_W-1:0] luhn_total_reg;
    logic [cnlc_pkg::CNT_W-1:0]   digit_count_reg;

    always_comb
    begin
        bcd_conv = bcd_reg;
        for (int k = 0; k < cnlc_pkg::STEP_BITS; k++)
        begin
            bcd_conv = cnlc_pkg::bcd_shift(bcd_conv, bin_reg[cnlc_pkg::NUM_W-1-k]);
        end
    end

    // odd positions (second, fourth, ...) are doubled
    assign digit   = bcd_reg[3:0];
    assign contrib = cmd.pos[0] ? cnlc_pkg::dbl_sum(digit) : digit;
    assign mod_sum = {1'b0, mod_reg} + {1'b0, contrib};
    assign mod_next = (mod_sum >= 5'd10) ? 4'(mod_sum - 5'd10) : mod_sum[3:0];

    always_comb
    begin
        cls = cnlc_pkg::CLS_INVALID;
        if (mod_reg == 4'd0)
        begin
            if (count_reg == cnlc_pkg::LEN_15 && top_reg == 4'd3
                && (second_reg == 4'd4 || second_reg == 4'd7))
            begin
                cls = cnlc_pkg::CLS_FIFTEEN;
            end
            else if (count_reg == cnlc_pkg::LEN_16 && top_reg == 4'd5
                && second_reg >= 4'd1 && second_reg <= 4'd5)
            begin
                cls = cnlc_pkg::CLS_SIXTEEN;
            end
            else if ((count_reg == cnlc_pkg::LEN_13 || count_reg == cnlc_pkg::LEN_16)
                && top_reg == 4'd4)
            begin
                cls = cnlc_pkg::CLS_LEAD4;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg    <= number_value;
            bcd_reg    <= '0;
            total_reg  <= '0;
            mod_reg    <= '0;
            count_reg  <= '0;
            top_reg    <= '0;
            second_reg <= '0;
            prev_reg   <= '0;
        end
        else if (cmd.conv)
        begin
            bin_reg <= bin_reg << cnlc_pkg::STEP_BITS;
            bcd_reg <= bcd_conv;
        end
        else if (cmd.walk)
        begin
            bcd_reg   <= bcd_reg >> 4;
            total_reg <= total_reg + cnlc_pkg::TOTAL_W'(contrib);
            mod_reg   <= mod_next;
            prev_reg  <= digit;
            if (digit != 4'd0)
            begin
                count_reg  <= cmd.pos + 1'b1;
                top_reg    <= digit;
                second_reg <= prev_reg;
            end
        end

        if (cmd.finish)
        begin
            card_class_reg  <= cls;
            checksum_ok_reg <= (mod_reg == 4'd0);
            luhn_total_reg  <= total_reg;
            digit_count_reg <= count_reg;
        end
    end

    assign card_class  = card_class_reg;
    assign checksum_ok = checksum_ok_reg;
    assign luhn_total  = luhn_total_reg;
    assign digit_count = digit_count_reg;

endmodule

`default_nettype wire

// ===== rtl/card_number_luhn_classifier.sv =====
// Card number Luhn check and issuer class; top level joining cnlc_ctrl and cnlc_dp.
// Depends on cnlc_pkg, cnlc_ctrl, cnlc_dp.
// Each word passes through 21 conversion steps of 3 bits, 19 digit steps and one result step
// before out_valid. The next word is taken only back in idle; the result step waits
// while out_stall holds the previous result. in_stall stays high while busy.
// Reset (rst_n low, async) empties the block; out_valid drops immediately.
`default_nettype none

module card_number_luhn_classifier (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [cnlc_pkg::NUM_W-1:0]    number_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         card_class,
    output logic                               checksum_ok,
    output logic [cnlc_pkg::TOTAL_W-1:0]       luhn_total,
    output logic [cnlc_pkg::CNT_W-1:0]         digit_count
);

    cnlc_pkg::cnlc_cmd_t cmd;

    cnlc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    cnlc_dp u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .number_value (number_value),
        .card_class   (card_class),
        .checksum_ok  (checksum_ok),
        .luhn_total   (luhn_total),
        .digit_count  (digit_count)
    );

endmodule

`default_nettype wire
